@@ rtl/srtf_pkg.sv @@
// srtf_pkg: shared types and codes for the SRTF tick scheduler.
// No dependencies; used by srtf_tick_scheduler.
`default_nettype none

package srtf_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ValW    = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 168;

  localparam logic [StatW-1:0] STAT_LOADED = 2'd0;
  localparam logic [StatW-1:0] STAT_REJECT = 2'd1;
  localparam logic [StatW-1:0] STAT_RUN    = 2'd2;
  localparam logic [StatW-1:0] STAT_IDLE   = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SEL,
    S_UPD,
    S_TAT,
    S_WAIT,
    S_DONE
  } seq_state_e;

endpackage

`default_nettype wire

@@ rtl/srtf_tick_scheduler.sv @@
// srtf_tick_scheduler: preemptive shortest-remaining-time-first scheduler.
// Depends on srtf_pkg (state enum, status codes, field widths).
//
//  channel   dir  tdata                              tuser
//  s_axis    in   arrival_time, burst_time           mode
//  m_axis    out  slot .. all_done (166 bits used)   status
//
// A load item goes from idle to the done step. A tick item scans each loaded
// slot, drains the read, selects and, when a process runs, updates the slot,
// adding turnaround and waiting steps when it finishes: the scan reads one
// slot per cycle through the table memory's read port and one compare unit.
// Reset clears the counters, clock, started flags and output valid, and returns to idle.
// A result waits in the output register; the block stays busy in its
// final step until that register is free.
`default_nettype none

module srtf_tick_scheduler #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] arrival_time, [31:16] burst_time
  input  wire logic [srtf_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [0] mode
  input  wire logic                           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [3:0] slot, [35:4] tick_end_time, [36] finished, [68:37] start_time,
  // [100:69] turnaround, [132:101] waiting, [164:133] response,
  // [165] all_done, [167:166] zero
  output logic [srtf_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // [1:0] status
  output logic [srtf_pkg::StatW-1:0]          m_axis_tuser_o
);

  localparam int unsigned SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_PROCS);
  localparam int unsigned TW = srtf_pkg::TimeW;
  localparam int unsigned VW = srtf_pkg::ValW;

  srtf_pkg::seq_state_e state_q, state_d;

  // table memories
  logic [VW-1:0] arr_mem [MAX_PROCS];
  logic [VW-1:0] bur_mem [MAX_PROCS];
  logic [VW-1:0] rem_mem [MAX_PROCS];
  logic [TW-1:0] fs_mem  [MAX_PROCS];
  logic [MAX_PROCS-1:0] started_q;

  logic [CW-1:0] count_q, done_cnt_q, idx_q;
  logic [TW-1:0] time_q;

  logic [SW-1:0] rd_addr;
  logic [VW-1:0] rd_arr_q, rd_bur_q, rd_rem_q;
  logic [TW-1:0] rd_fs_q;
  logic          rd_vld_q;
  logic [SW-1:0] rd_idx_q;

  logic          found_q;
  logic [SW-1:0] best_q;
  logic [VW-1:0] best_rem_q;

  // result under construction
  logic [srtf_pkg::StatW-1:0] res_stat_q;
  logic [srtf_pkg::SlotW-1:0] res_slot_q;
  logic                       res_fin_q;
  logic [TW-1:0]              res_st_q, res_tat_q, res_wt_q, res_resp_q;

  logic                          out_vld_q;
  logic [srtf_pkg::OutDataW-1:0] out_data_q;
  logic [srtf_pkg::StatW-1:0]    out_user_q;

  logic          accept;
  logic          in_mode;
  logic [VW-1:0] in_arr, in_bur;
  logic          load_ok;
  logic          cand_better;
  logic [VW-1:0] new_rem;
  logic [TW-1:0] fs_val;
  logic          out_free;
  logic [SW+srtf_pkg::SlotW-1:0] best_ext, cnt_ext;

  assign in_mode = s_axis_tuser_i;
  assign in_arr  = s_axis_tdata_i[VW-1:0];
  assign in_bur  = s_axis_tdata_i[2*VW-1:VW];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign load_ok = (count_q != MaxCnt) && (in_bur != '0);
  assign out_free = !out_vld_q || m_axis_tready_i;

  assign best_ext = {{srtf_pkg::SlotW{1'b0}}, best_q};
  assign cnt_ext  = {{srtf_pkg::SlotW{1'b0}}, count_q[SW-1:0]};

  // one compare unit shared across the scan
  assign cand_better = ({{(TW-VW){1'b0}}, rd_arr_q} <= time_q) && (rd_rem_q != '0) &&
                       (!found_q || (rd_rem_q < best_rem_q));

  assign new_rem = best_rem_q - VW'(1);
  assign fs_val  = started_q[best_q] ? rd_fs_q : time_q;

  // outside the scan the read port stays on the chosen slot for the closing steps
  assign rd_addr = (state_q == srtf_pkg::S_SCAN) ? idx_q[SW-1:0] : best_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srtf_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (in_mode == srtf_pkg::MODE_TICK) ? srtf_pkg::S_SCAN : srtf_pkg::S_DONE;
        end
      end
      srtf_pkg::S_SCAN: begin
        if (idx_q >= count_q) state_d = srtf_pkg::S_DRAIN;
      end
      srtf_pkg::S_DRAIN: state_d = srtf_pkg::S_SEL;
      srtf_pkg::S_SEL:   state_d = found_q ? srtf_pkg::S_UPD : srtf_pkg::S_DONE;
      srtf_pkg::S_UPD:   state_d = (new_rem == '0) ? srtf_pkg::S_TAT : srtf_pkg::S_DONE;
      srtf_pkg::S_TAT:   state_d = srtf_pkg::S_WAIT;
      srtf_pkg::S_WAIT:  state_d = srtf_pkg::S_DONE;
      srtf_pkg::S_DONE: begin
        if (out_free) state_d = srtf_pkg::S_IDLE;
      end
      default: state_d = srtf_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = (state_q == srtf_pkg::S_IDLE);
    m_axis_tvalid_o = out_vld_q;
    m_axis_tdata_o  = out_data_q;
    m_axis_tuser_o  = out_user_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (accept && in_mode == srtf_pkg::MODE_LOAD && load_ok) begin
      arr_mem[count_q[SW-1:0]] <= in_arr;
      bur_mem[count_q[SW-1:0]] <= in_bur;
    end
    rd_arr_q <= arr_mem[rd_addr];
    rd_bur_q <= bur_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_mode == srtf_pkg::MODE_LOAD && load_ok) begin
      rem_mem[count_q[SW-1:0]] <= in_bur;
    end else if (state_q == srtf_pkg::S_UPD) begin
      rem_mem[best_q] <= new_rem;
    end
    rd_rem_q <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == srtf_pkg::S_UPD && !started_q[best_q]) begin
      fs_mem[best_q] <= time_q;
    end
    rd_fs_q <= fs_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= '0;
      count_q    <= '0;
      done_cnt_q <= '0;
      idx_q      <= '0;
      time_q     <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == srtf_pkg::S_SCAN) && (idx_q < count_q);
      if (state_q == srtf_pkg::S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        srtf_pkg::S_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          if (accept && in_mode == srtf_pkg::MODE_LOAD && load_ok) begin
            started_q[count_q[SW-1:0]] <= 1'b0;
            count_q <= count_q + CW'(1);
          end
        end
        srtf_pkg::S_SCAN: begin
          if (idx_q < count_q) idx_q <= idx_q + CW'(1);
        end
        srtf_pkg::S_SEL: begin
          if (!found_q) time_q <= time_q + TW'(1);
        end
        srtf_pkg::S_UPD: begin
          started_q[best_q] <= 1'b1;
          time_q <= time_q + TW'(1);
          if (new_rem == '0) done_cnt_q <= done_cnt_q + CW'(1);
        end
        default: ;
      endcase
      if (rd_vld_q && cand_better) found_q <= 1'b1;
    end
  end

  // scan result and payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q[SW-1:0];
    if (rd_vld_q && cand_better) begin
      best_q     <= rd_idx_q;
      best_rem_q <= rd_rem_q;
    end
    case (state_q)
      srtf_pkg::S_IDLE: begin
        res_fin_q  <= 1'b0;
        res_st_q   <= '0;
        res_tat_q  <= '0;
        res_wt_q   <= '0;
        res_resp_q <= '0;
        res_slot_q <= (in_mode == srtf_pkg::MODE_LOAD && load_ok) ?
                      cnt_ext[srtf_pkg::SlotW-1:0] : '0;
        res_stat_q <= (in_mode != srtf_pkg::MODE_LOAD) ? srtf_pkg::STAT_IDLE :
                      load_ok ? srtf_pkg::STAT_LOADED : srtf_pkg::STAT_REJECT;
      end
      srtf_pkg::S_UPD: begin
        res_stat_q <= srtf_pkg::STAT_RUN;
        res_slot_q <= best_ext[srtf_pkg::SlotW-1:0];
        if (new_rem == '0) begin
          res_fin_q <= 1'b1;
          res_st_q  <= fs_val;
        end
      end
      srtf_pkg::S_TAT: begin
        // clock already advanced past the final tick
        res_tat_q  <= time_q - {{(TW-VW){1'b0}}, rd_arr_q};
        res_resp_q <= res_st_q - {{(TW-VW){1'b0}}, rd_arr_q};
      end
      srtf_pkg::S_WAIT: begin
        res_wt_q <= res_tat_q - {{(TW-VW){1'b0}}, rd_bur_q};
      end
      srtf_pkg::S_DONE: begin
        if (out_free) begin
          out_user_q <= res_stat_q;
          out_data_q <= {2'b00, (done_cnt_q == count_q), res_resp_q, res_wt_q,
                         res_tat_q, res_st_q, res_fin_q, time_q, res_slot_q};
        end
      end
      default: ;
    endcase
  end

  // checks
  a_done_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_cnt_q <= count_q)
    else $error("completed count exceeds process count");

  a_fin_only_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[36]) |-> (m_axis_tuser_o == srtf_pkg::STAT_RUN))
    else $error("finished flag on a non-run result");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == srtf_pkg::STAT_IDLE ||
                         m_axis_tuser_o == srtf_pkg::STAT_REJECT))
    |-> (m_axis_tdata_o[3:0] == 4'd0 && !m_axis_tdata_o[36]))
    else $error("idle or reject result carries a slot or finish");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_mode == srtf_pkg::MODE_TICK) |=> !s_axis_tready_o)
    else $error("ready during tick scan");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srtf_pkg::S_UPD) |=> (time_q == $past(time_q) + 32'd1))
    else $error("clock did not advance on a run tick");

endmodule

`default_nettype wire
